// ===== rtl/kts_pkg.sv =====
package kts_pkg;

    // Fixed widths of the command and result ports.
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int IDX_W    = 8;
    localparam int TOT_W    = 9;
    localparam int KEY_IO_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_POP     = 3'd1,
        OP_FIND    = 3'd2,
        OP_BRACKET = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Kind of result the datapath captures into its output registers.
    typedef enum logic [3:0] {
        RES_NONE,
        RES_APPEND,
        RES_FULL,
        RES_EMPTY,
        RES_POP,
        RES_MATCH,
        RES_HIT,
        RES_BELOW,
        RES_ABOVE,
        RES_BETWEEN,
        RES_RANGE,
        RES_READ
    } t_res;

    // Read address source for the key memory.
    typedef enum logic [2:0] {
        RS_PTR,
        RS_ZERO,
        RS_HI,
        RS_MID,
        RS_RIDX
    } t_rsel;

    typedef struct packed {
        logic  load;
        logic  rd_en;
        t_rsel rd_sel;
        logic  wr_en;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  scan_init;
        logic  br_init;
        logic  lo_take_mid;
        logic  hi_take_mid;
        logic  emit;
        t_res  res;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic range_err;
        logic eq;
        logic lt;
        logic gt;
        logic ptr_zero;
        logic pend;
        logic span_gt1;
    } t_dp_sts;

endpackage

// ===== rtl/key_table_search_engine.sv =====
// Append, pop, out-of-range read and unused opcodes reply straight from decode; a read
// first reads the entry, find-or-append scans from the top entry down (one memory read
// per cycle), and bracket search checks the first and last entries, then halves the span.
// Throughput: one command at a time; busy falls as the result is strobed, so a new
// command may start in the strobe cycle. The receiver cannot stall results.
// Reset (synchronous, active low) empties the table; stored keys are not cleared.
module key_table_search_engine
    import kts_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_IO_W-1:0] i_key,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                o_valid,
    output logic [ST_W-1:0]     o_status,
    output logic                o_found,
    output logic [IDX_W-1:0]    o_result_index,
    output logic [IDX_W-1:0]    o_left_index,
    output logic                o_left_valid,
    output logic [IDX_W-1:0]    o_right_index,
    output logic                o_right_valid,
    output logic [KEY_IO_W-1:0] o_read_key,
    output logic [TOT_W-1:0]    o_entry_total
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    kts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    kts_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_key          (i_key),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_result_index (o_result_index),
        .o_left_index   (o_left_index),
        .o_left_valid   (o_left_valid),
        .o_right_index  (o_right_index),
        .o_right_valid  (o_right_valid),
        .o_read_key     (o_read_key),
        .o_entry_total  (o_entry_total)
    );

endmodule

// ===== rtl/kts_dp.sv =====
module kts_dp
    import kts_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [KEY_IO_W-1:0] i_key,
    input  logic [IDX_W-1:0]    i_read_index,
    output logic                o_valid,
    output logic [ST_W-1:0]     o_status,
    output logic                o_found,
    output logic [IDX_W-1:0]    o_result_index,
    output logic [IDX_W-1:0]    o_left_index,
    output logic                o_left_valid,
    output logic [IDX_W-1:0]    o_right_index,
    output logic                o_right_valid,
    output logic [KEY_IO_W-1:0] o_read_key,
    output logic [TOT_W-1:0]    o_entry_total
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = CNT_W + IDX_W;

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;
    logic [KEY_WIDTH-1:0] r_key;
    logic [IDX_W-1:0]     r_ridx;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     r_ptr;
    logic                 r_pend;
    logic [ADDR_W-1:0]    r_lo;
    logic [ADDR_W-1:0]    r_hi;
    logic [ADDR_W-1:0]    r_probe;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    mid;
    logic [ADDR_W:0]      span;

    logic                 r_valid;
    logic [ST_W-1:0]      r_status;
    logic                 r_found;
    logic [IDX_W-1:0]     r_result_index;
    logic [IDX_W-1:0]     r_left_index;
    logic                 r_left_valid;
    logic [IDX_W-1:0]     r_right_index;
    logic                 r_right_valid;
    logic [KEY_IO_W-1:0]  r_read_key;
    logic [TOT_W-1:0]     r_entry_total;

    assign mid  = ADDR_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign span = {1'b0, r_hi} - {1'b0, r_lo};

    always_comb begin
        case (i_cmd.rd_sel)
            RS_PTR:  rd_addr = ADDR_W'(r_ptr - CNT_W'(1));
            RS_ZERO: rd_addr = '0;
            RS_HI:   rd_addr = r_hi;
            RS_MID:  rd_addr = mid;
            RS_RIDX: rd_addr = ADDR_W'(r_ridx);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CNT_W'(DEPTH));
    assign o_sts.range_err = (CMP_W'(r_ridx) >= CMP_W'(r_count));
    assign o_sts.eq        = (r_key == r_rdata);
    assign o_sts.lt        = (r_key < r_rdata);
    assign o_sts.gt        = (r_key > r_rdata);
    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_sts.pend      = r_pend;
    assign o_sts.span_gt1  = (span > (ADDR_W + 1)'(1));

    // Key memory: one write port at the table end, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[ADDR_W'(r_count)] <= r_key;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.scan_init) begin
                r_ptr  <= r_count;
                r_pend <= 1'b0;
            end else if (i_cmd.rd_en && i_cmd.rd_sel == RS_PTR) begin
                r_ptr  <= r_ptr - CNT_W'(1);
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= KEY_WIDTH'(i_key);
            r_ridx <= i_read_index;
        end
        if (i_cmd.rd_en) begin
            r_probe <= rd_addr;
        end
        if (i_cmd.br_init) begin
            r_lo <= '0;
            r_hi <= ADDR_W'(r_count - CNT_W'(1));
        end else begin
            if (i_cmd.lo_take_mid) begin
                r_lo <= r_probe;
            end
            if (i_cmd.hi_take_mid) begin
                r_hi <= r_probe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // Result capture; fields that do not apply to a result are zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status       <= ST_OK;
            r_found        <= 1'b0;
            r_result_index <= '0;
            r_left_index   <= '0;
            r_left_valid   <= 1'b0;
            r_right_index  <= '0;
            r_right_valid  <= 1'b0;
            r_read_key     <= '0;
            r_entry_total  <= TOT_W'(n_count);
            case (i_cmd.res)
                RES_APPEND: begin
                    r_result_index <= IDX_W'(r_count);
                end
                RES_FULL: begin
                    r_status <= ST_FULL;
                end
                RES_EMPTY: begin
                    r_status <= ST_EMPTY;
                end
                RES_POP: begin
                    r_result_index <= IDX_W'(n_count);
                end
                RES_MATCH: begin
                    r_found        <= 1'b1;
                    r_result_index <= IDX_W'(r_probe);
                end
                RES_HIT: begin
                    r_found        <= 1'b1;
                    r_result_index <= IDX_W'(r_probe);
                    r_left_index   <= IDX_W'(r_probe);
                    r_left_valid   <= 1'b1;
                    r_right_index  <= IDX_W'(r_probe);
                    r_right_valid  <= 1'b1;
                end
                RES_BELOW: begin
                    r_right_valid <= 1'b1;
                end
                RES_ABOVE: begin
                    r_left_index <= IDX_W'(r_hi);
                    r_left_valid <= 1'b1;
                end
                RES_BETWEEN: begin
                    r_left_index  <= IDX_W'(r_lo);
                    r_left_valid  <= 1'b1;
                    r_right_index <= IDX_W'(r_hi);
                    r_right_valid <= 1'b1;
                end
                RES_RANGE: begin
                    r_status <= ST_RANGE;
                end
                RES_READ: begin
                    r_result_index <= IDX_W'(r_probe);
                    r_read_key     <= KEY_IO_W'(r_rdata);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_result_index = r_result_index;
    assign o_left_index   = r_left_index;
    assign o_left_valid   = r_left_valid;
    assign o_right_index  = r_right_index;
    assign o_right_valid  = r_right_valid;
    assign o_read_key     = r_read_key;
    assign o_entry_total  = r_entry_total;

endmodule

// ===== rtl/kts_ctrl.sv =====
module kts_ctrl
    import kts_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_busy,
    output t_dp_cmd         o_cmd,
    input  t_dp_sts         i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_BR_FIRST,
        S_BR_LAST,
        S_BR_LOOP,
        S_BR_MID,
        S_READ
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_op     r_op;
    t_op     n_op;
    logic    r_busy;
    logic    n_busy;
    t_dp_cmd cmd;

    function automatic t_dp_cmd append_cmd(input logic full);
        t_dp_cmd c;
        c      = '0;
        c.emit = 1'b1;
        if (full) begin
            c.res = RES_FULL;
        end else begin
            c.wr_en   = 1'b1;
            c.cnt_inc = 1'b1;
            c.res     = RES_APPEND;
        end
        return c;
    endfunction

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_op    = r_op;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_op     = t_op'(i_opcode);
                    n_busy   = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
                unique case (r_op)
                    OP_APPEND: begin
                        cmd = append_cmd(i_sts.full);
                    end
                    OP_POP: begin
                        cmd.emit = 1'b1;
                        if (i_sts.empty) begin
                            cmd.res = RES_EMPTY;
                        end else begin
                            cmd.cnt_dec = 1'b1;
                            cmd.res     = RES_POP;
                        end
                    end
                    OP_FIND: begin
                        cmd.scan_init = 1'b1;
                        n_state       = S_FIND;
                        n_busy        = 1'b1;
                    end
                    OP_BRACKET: begin
                        if (i_sts.empty) begin
                            cmd.emit = 1'b1;
                            cmd.res  = RES_EMPTY;
                        end else begin
                            cmd.br_init = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RS_ZERO;
                            n_state     = S_BR_FIRST;
                            n_busy      = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.range_err) begin
                            cmd.emit = 1'b1;
                            cmd.res  = RES_RANGE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RS_RIDX;
                            n_state    = S_READ;
                            n_busy     = 1'b1;
                        end
                    end
                    default: begin
                        cmd.emit = 1'b1;
                        cmd.res  = RES_NONE;
                    end
                endcase
            end
            // One read per cycle from the top entry down; the compare of an
            // entry overlaps the read of the one below it.
            S_FIND: begin
                if (i_sts.pend && i_sts.eq) begin
                    cmd.emit = 1'b1;
                    cmd.res  = RES_MATCH;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end else if (i_sts.ptr_zero) begin
                    cmd     = append_cmd(i_sts.full);
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_PTR;
                end
            end
            S_BR_FIRST: begin
                if (i_sts.lt || i_sts.eq) begin
                    cmd.emit = 1'b1;
                    cmd.res  = i_sts.eq ? RES_HIT : RES_BELOW;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_HI;
                    n_state    = S_BR_LAST;
                end
            end
            S_BR_LAST: begin
                if (i_sts.gt || i_sts.eq) begin
                    cmd.emit = 1'b1;
                    cmd.res  = i_sts.eq ? RES_HIT : RES_ABOVE;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end else begin
                    n_state = S_BR_LOOP;
                end
            end
            S_BR_LOOP: begin
                if (i_sts.span_gt1) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RS_MID;
                    n_state    = S_BR_MID;
                end else begin
                    cmd.emit = 1'b1;
                    cmd.res  = RES_BETWEEN;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end
            end
            S_BR_MID: begin
                if (i_sts.eq) begin
                    cmd.emit = 1'b1;
                    cmd.res  = RES_HIT;
                    n_state  = S_IDLE;
                    n_busy   = 1'b0;
                end else begin
                    cmd.lo_take_mid = i_sts.gt;
                    cmd.hi_take_mid = !i_sts.gt;
                    n_state         = S_BR_LOOP;
                end
            end
            S_READ: begin
                cmd.emit = 1'b1;
                cmd.res  = RES_READ;
                n_state  = S_IDLE;
                n_busy   = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_APPEND;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;
    assign o_cmd  = cmd;

endmodule

// ===== tb/key_table_search_engine_tb.sv =====
`timescale 1ns / 1ps

module key_table_search_engine_tb;
    import kts_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int ITEM_TARGET = 1150;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int END_SETTLE  = 300;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [KEY_IO_W-1:0] key;
        logic [IDX_W-1:0]    ridx;
        bit                  drain;
    } t_table_cmd;

    typedef struct {
        logic [ST_W-1:0]     status;
        logic                found;
        logic [IDX_W-1:0]    result_index;
        logic [IDX_W-1:0]    left_index;
        logic                left_valid;
        logic [IDX_W-1:0]    right_index;
        logic                right_valid;
        logic [KEY_IO_W-1:0] read_key;
        logic [TOT_W-1:0]    entry_total;
    } t_table_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_opcode = '0;
    logic [KEY_IO_W-1:0] i_key = '0;
    logic [IDX_W-1:0]    i_read_index = '0;
    logic                o_valid;
    logic [ST_W-1:0]     o_status;
    logic                o_found;
    logic [IDX_W-1:0]    o_result_index;
    logic [IDX_W-1:0]    o_left_index;
    logic                o_left_valid;
    logic [IDX_W-1:0]    o_right_index;
    logic                o_right_valid;
    logic [KEY_IO_W-1:0] o_read_key;
    logic [TOT_W-1:0]    o_entry_total;

    key_table_search_engine #(
        .DEPTH     (TABLE_DEPTH),
        .KEY_WIDTH (32)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_result_index (o_result_index),
        .o_left_index   (o_left_index),
        .o_left_valid   (o_left_valid),
        .o_right_index  (o_right_index),
        .o_right_valid  (o_right_valid),
        .o_read_key     (o_read_key),
        .o_entry_total  (o_entry_total)
    );

    // Commands still to be sent, and the stimulus side's own view of the table contents.
    t_table_cmd          pending_cmds[$];
    logic [KEY_IO_W-1:0] planned_keys[$];

    // Predicted table state.
    logic [KEY_IO_W-1:0] key_mem [TABLE_DEPTH];
    int unsigned         entry_cnt = 0;

    // Replies predicted at acceptance; never popped, walked by n_checked.
    t_table_reply        expected_replies[$];
    int unsigned         n_issued = 0;
    int unsigned         n_checked = 0;
    int unsigned         n_total = 0;
    int unsigned         n_mismatch = 0;
    int unsigned         cycle_cnt = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_table_reply table_op_result(t_table_cmd c);
        t_table_reply r;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int unsigned  hit_idx;
        bit           hit;
        r = '{default: '0};
        hit = 1'b0;
        hit_idx = 0;
        case (c.op)
            OP_APPEND: begin
                if (entry_cnt >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[entry_cnt] = c.key;
                    r.result_index = entry_cnt[IDX_W-1:0];
                    entry_cnt++;
                end
            end
            OP_POP: begin
                if (entry_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    entry_cnt--;
                    r.result_index = entry_cnt[IDX_W-1:0];
                end
            end
            OP_FIND: begin
                // Scan from the top so the highest matching index wins.
                for (int i = int'(entry_cnt) - 1; i >= 0 && !hit; i--) begin
                    if (key_mem[i] == c.key) begin
                        hit = 1'b1;
                        hit_idx = i;
                    end
                end
                if (hit) begin
                    r.found = 1'b1;
                    r.result_index = hit_idx[IDX_W-1:0];
                end else if (entry_cnt >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[entry_cnt] = c.key;
                    r.result_index = entry_cnt[IDX_W-1:0];
                    entry_cnt++;
                end
            end
            OP_BRACKET: begin
                if (entry_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    lo = 0;
                    hi = entry_cnt - 1;
                    if (c.key < key_mem[lo]) begin
                        r.right_valid = 1'b1;
                    end else if (c.key == key_mem[lo]) begin
                        hit = 1'b1;
                        hit_idx = lo;
                    end else if (c.key > key_mem[hi]) begin
                        r.left_index = hi[IDX_W-1:0];
                        r.left_valid = 1'b1;
                    end else if (c.key == key_mem[hi]) begin
                        hit = 1'b1;
                        hit_idx = hi;
                    end else begin
                        while (hi - lo > 1 && !hit) begin
                            mid = (lo + hi) >> 1;
                            if (c.key == key_mem[mid]) begin
                                hit = 1'b1;
                                hit_idx = mid;
                            end else if (c.key > key_mem[mid]) begin
                                lo = mid;
                            end else begin
                                hi = mid;
                            end
                        end
                        if (!hit) begin
                            r.left_index  = lo[IDX_W-1:0];
                            r.left_valid  = 1'b1;
                            r.right_index = hi[IDX_W-1:0];
                            r.right_valid = 1'b1;
                        end
                    end
                    if (hit) begin
                        r.found        = 1'b1;
                        r.result_index = hit_idx[IDX_W-1:0];
                        r.left_index   = hit_idx[IDX_W-1:0];
                        r.left_valid   = 1'b1;
                        r.right_index  = hit_idx[IDX_W-1:0];
                        r.right_valid  = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (c.ridx >= entry_cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    r.result_index = c.ridx;
                    r.read_key = key_mem[c.ridx];
                end
            end
            default: begin
            end
        endcase
        r.entry_total = entry_cnt[TOT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [KEY_IO_W-1:0] key,
                             logic [IDX_W-1:0] ridx, bit drain);
        t_table_cmd c;
        bit         present;
        c = '{op: op, key: key, ridx: ridx, drain: drain};
        pending_cmds.push_back(c);
        present = 1'b0;
        case (op)
            OP_APPEND: begin
                if (planned_keys.size() < TABLE_DEPTH) planned_keys.push_back(key);
            end
            OP_POP: begin
                if (planned_keys.size() != 0) void'(planned_keys.pop_back());
            end
            OP_FIND: begin
                foreach (planned_keys[i]) if (planned_keys[i] == key) present = 1'b1;
                if (!present && planned_keys.size() < TABLE_DEPTH) planned_keys.push_back(key);
            end
            default: begin
            end
        endcase
    endtask

    // Keys that land on, next to, or outside the stored entries.
    function automatic logic [KEY_IO_W-1:0] probe_key();
        int unsigned         n;
        logic [KEY_IO_W-1:0] base;
        n = planned_keys.size();
        if (n == 0 || $urandom_range(4) == 0) begin
            if ($urandom_range(2) == 0) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            return $urandom;
        end
        base = planned_keys[$urandom_range(n - 1)];
        case ($urandom_range(2))
            0: return base;
            1: return base + 1;
            default: return base - 1;
        endcase
    endfunction

    // Empties the table; the first pop waits for all replies to come back.
    task automatic empty_table();
        queue_cmd(OP_POP, $urandom, IDX_W'($urandom_range(255)), 1'b1);
        while (planned_keys.size() != 0) begin
            queue_cmd(OP_POP, $urandom, IDX_W'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic fill_sorted(int unsigned count);
        logic [KEY_IO_W-1:0] fresh[$];
        int unsigned         sel;
        for (int unsigned k = 0; k < count; k++) begin
            sel = $urandom_range(15);
            if (sel == 0) fresh.push_back(32'h0);
            else if (sel == 1) fresh.push_back(32'hFFFF_FFFF);
            else fresh.push_back($urandom);
        end
        fresh.sort();
        foreach (fresh[k]) begin
            queue_cmd(($urandom_range(3) == 0) ? OP_FIND : OP_APPEND, fresh[k],
                      IDX_W'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic random_ops(int unsigned count);
        int unsigned roll;
        int unsigned n;
        for (int unsigned k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            n = planned_keys.size();
            if (roll < 35) begin
                queue_cmd(OP_BRACKET, probe_key(), IDX_W'($urandom_range(255)), 1'b0);
            end else if (roll < 50) begin
                queue_cmd(OP_FIND, $urandom_range(1) ? probe_key() : $urandom,
                          IDX_W'($urandom_range(255)), 1'b0);
            end else if (roll < 65) begin
                queue_cmd(OP_READ, $urandom,
                          IDX_W'((n != 0 && $urandom_range(1)) ? $urandom_range(n - 1)
                                                               : $urandom_range(255)),
                          1'b0);
            end else if (roll < 75) begin
                queue_cmd(OP_APPEND, $urandom, IDX_W'($urandom_range(255)), 1'b0);
            end else if (roll < 85) begin
                queue_cmd(OP_POP, $urandom, IDX_W'($urandom_range(255)), 1'b0);
            end else if (roll < 90) begin
                queue_cmd(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), $urandom,
                          IDX_W'($urandom_range(255)), 1'b0);
            end else begin
                queue_cmd(OP_BRACKET, $urandom, IDX_W'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin
        // Empty table corners and the unused opcodes.
        queue_cmd(OP_POP,         32'h0,         8'd0,   1'b0);
        queue_cmd(OP_BRACKET,     32'h1234_5678, 8'd0,   1'b0);
        queue_cmd(OP_READ,        32'h0,         8'd0,   1'b0);
        queue_cmd(OP_SPARE_FIRST, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        queue_cmd(OP_SPARE_LAST,  32'h0,         8'h00, 1'b0);
        // A small sorted table, then every bracket outcome against it.
        queue_cmd(OP_APPEND,  32'h0000_0010, 8'd0, 1'b0);
        queue_cmd(OP_APPEND,  32'h0000_1000, 8'd0, 1'b0);
        queue_cmd(OP_APPEND,  32'h7FFF_FFFF, 8'd0, 1'b0);
        queue_cmd(OP_APPEND,  32'hFFFF_FFFE, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'h0000_0000, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'hFFFF_FFFF, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'h0000_0010, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'hFFFF_FFFE, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'h0000_1000, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'h0000_0800, 8'd0, 1'b0);
        queue_cmd(OP_BRACKET, 32'h8000_0000, 8'd0, 1'b0);
        // Find hits, a miss that appends, and a duplicate that must match the top copy.
        queue_cmd(OP_FIND,    32'h0000_1000, 8'd0, 1'b0);
        queue_cmd(OP_FIND,    32'h0BAD_F00D, 8'd0, 1'b0);
        queue_cmd(OP_APPEND,  32'h0000_0010, 8'd0, 1'b0);
        queue_cmd(OP_FIND,    32'h0000_0010, 8'd0, 1'b0);
        queue_cmd(OP_READ,    32'h0,         8'd0, 1'b0);
        queue_cmd(OP_READ,    32'h0,         8'd5, 1'b0);
        queue_cmd(OP_READ,    32'h0,         8'd6, 1'b0);
        queue_cmd(OP_READ,    32'hFFFF_FFFF, 8'hFF, 1'b0);
        queue_cmd(OP_POP,     32'h0,         8'd0, 1'b0);

        // Full table: sorted, topped up to capacity, then overflow attempts.
        empty_table();
        fill_sorted(TABLE_DEPTH);
        while (planned_keys.size() < TABLE_DEPTH) begin
            queue_cmd(OP_APPEND, 32'hFFFF_FFFF, 8'd0, 1'b0);
        end
        queue_cmd(OP_APPEND,  $urandom,          8'd0,  1'b0);
        queue_cmd(OP_FIND,    32'h5A5A_C3C3 ^ $urandom, 8'd0, 1'b0);
        queue_cmd(OP_FIND,    planned_keys[0],   8'd0,  1'b0);
        queue_cmd(OP_FIND,    planned_keys[TABLE_DEPTH - 1], 8'd0, 1'b0);
        queue_cmd(OP_READ,    32'h0,             8'hFF, 1'b0);
        queue_cmd(OP_BRACKET, planned_keys[128], 8'd0,  1'b0);
        random_ops(30);

        while (pending_cmds.size() < ITEM_TARGET) begin
            empty_table();
            fill_sorted(($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(12));
            random_ops($urandom_range(40, 15));
        end
        n_total = pending_cmds.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_issued == n_total && n_checked == n_total)) @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("key_table_search_engine verification clean");
        end else begin
            $display("key_table_search_engine verification failed");
        end
        $finish;
    end

    // Command driver. start stays up until the beat is taken; a drain command waits
    // until every earlier reply has been checked.
    always @(posedge i_clk) begin
        t_table_cmd nxt;
        bit         fire;
        bit         offer;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            fire = start && !busy;
            if (fire) begin
                expected_replies.push_back(table_op_result(pending_cmds.pop_front()));
                n_issued <= n_issued + 1;
            end
            if (!start || fire) begin
                offer = pending_cmds.size() != 0;
                if (!(n_issued >= 600 && n_issued < 850) && $urandom_range(99) < 25) begin
                    offer = 1'b0;
                end
                if (offer && pending_cmds[0].drain && (fire || n_checked != n_issued)) begin
                    offer = 1'b0;
                end
                if (offer) begin
                    nxt = pending_cmds[0];
                    i_opcode     <= nxt.op;
                    i_key        <= nxt.key;
                    i_read_index <= nxt.ridx;
                end
                start <= offer;
            end
        end
    end

    task automatic check_field(string name, logic [KEY_IO_W-1:0] want,
                               logic [KEY_IO_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_mismatch++;
        end
    endtask

    // Reply monitor.
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (n_checked >= n_issued) begin
                $error("reply beat with no command outstanding");
                n_mismatch++;
            end else begin
                want = expected_replies[n_checked];
                check_field("status",       want.status,       o_status);
                check_field("found",        want.found,        o_found);
                check_field("result_index", want.result_index, o_result_index);
                check_field("left_index",   want.left_index,   o_left_index);
                check_field("left_valid",   want.left_valid,   o_left_valid);
                check_field("right_index",  want.right_index,  o_right_index);
                check_field("right_valid",  want.right_valid,  o_right_valid);
                check_field("read_key",     want.read_key,     o_read_key);
                check_field("entry_total",  want.entry_total,  o_entry_total);
                n_checked <= n_checked + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("key_table_search_engine verification failed");
            $finish;
        end
    end

endmodule

// ===== key_table_search_engine.f =====
rtl/kts_pkg.sv
rtl/kts_dp.sv
rtl/kts_ctrl.sv
rtl/key_table_search_engine.sv
tb/key_table_search_engine_tb.sv
